/* hdl/c2p_pkg.sv */
package c2p_pkg;

    localparam int PAL_DEPTH    = 32;
    localparam int PAL_AW       = $clog2(PAL_DEPTH);
    localparam int PAL_CW       = $clog2(PAL_DEPTH + 1);
    localparam int COLOR_W      = 12;
    localparam int MAX_PLANES   = 8;
    localparam int GROUP_PIXELS = 8;
    localparam int POS_W        = $clog2(GROUP_PIXELS);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 72;

    localparam logic [7:0] MASKED_INDEX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_COUNT   = 3'd0,
        CFG_MASKED_MODE   = 3'd1,
        CFG_TRANSP_EN     = 3'd2,
        CFG_TRANSP_INDEX  = 3'd3,
        CFG_PALETTE_SIZE  = 3'd4
    } cfg_index_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load_we;
        logic capture;
        logic step;
        logic apply;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/palette_chunky_to_planar.sv */
// Channel   Direction  Payload
// s_axis    in         tuser: command; tdata: entry_index, red, green, blue, raster_index
// m_axis    out        tuser: colour_missing; tdata: plane_bytes, mask_byte
// cfg       in         cfg_index selects the register, cfg_wr_data holds the value
//
// A palette load is taken in the idle state, which stays ready. A pixel is captured, then
// the first palette-size entries are read and compared in index order until one matches
// or none is left; a transparent pixel needs no search, and the eighth pixel of a group
// then moves the group out. The single read port of the palette memory compares one entry per cycle.
// Reset is asynchronous and clears control state; palette contents stay undefined.
// A stalled result holds the output register; the next group's eighth pixel waits for it.
module palette_chunky_to_planar (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index[4:0], red[12:5], green[20:13], blue[28:21], raster_index[36:29]
    input  logic [c2p_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // plane_bytes[63:0], mask_byte[71:64]
    output logic [c2p_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // colour_missing[0]
    output logic [0:0]                          m_axis_tuser,
    input  logic                                cfg_wr_en,
    input  logic [c2p_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [c2p_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import c2p_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    c2p_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser[0]),
        .in_ready   (s_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    c2p_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_axis_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_missing (m_axis_tuser[0])
    );

endmodule

/* hdl/c2p_ctrl.sv */
module c2p_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    output logic                in_ready,
    input  c2p_pkg::dp_status_t status,
    output c2p_pkg::dp_cmd_t    cmd
);
    import c2p_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command_t'(in_command) == CMD_PIXEL)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (status.done)
                begin
                    cmd.apply  = 1'b1;
                    state_next = status.last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/c2p_datapath.sv */
module c2p_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [c2p_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [c2p_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic [c2p_pkg::IN_TDATA_W-1:0]      in_data,
    input  c2p_pkg::dp_cmd_t                    cmd,
    output c2p_pkg::dp_status_t                 status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [c2p_pkg::OUT_TDATA_W-1:0]     out_data,
    output logic                                out_missing
);
    import c2p_pkg::*;

    logic [4:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] raster_index;

    assign entry_index  = in_data[4:0];
    assign red          = in_data[12:5];
    assign green        = in_data[20:13];
    assign blue         = in_data[28:21];
    assign raster_index = in_data[36:29];

    logic [3:0] plane_count_reg;
    logic       masked_mode_reg;
    logic       transp_en_reg;
    logic [7:0] transp_index_reg;
    logic [5:0] palette_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg  <= 4'd4;
            masked_mode_reg  <= 1'b0;
            transp_en_reg    <= 1'b0;
            transp_index_reg <= 8'd0;
            palette_size_reg <= 6'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PLANE_COUNT:  plane_count_reg  <= cfg_wr_data[3:0];
                CFG_MASKED_MODE:  masked_mode_reg  <= cfg_wr_data[0];
                CFG_TRANSP_EN:    transp_en_reg    <= cfg_wr_data[0];
                CFG_TRANSP_INDEX: transp_index_reg <= cfg_wr_data;
                CFG_PALETTE_SIZE: palette_size_reg <= cfg_wr_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;
    logic [PAL_AW-1:0]  rd_idx_reg;
    logic               rd_vld_reg;
    logic [PAL_CW-1:0]  addr_reg;
    logic [PAL_CW-1:0]  limit_reg;
    logic [COLOR_W-1:0] key_reg;
    logic               transp_reg;
    logic               masked_reg;
    logic [3:0]         planes_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [63:0]        plane_acc_reg;
    logic [7:0]         mask_acc_reg;
    logic               missing_reg;
    logic               out_valid_reg;
    logic [63:0]        plane_out_reg;
    logic [7:0]         mask_out_reg;
    logic               missing_out_reg;

    logic               addr_end;
    logic               hit;
    logic [7:0]         idx_raw;
    logic [7:0]         idx;
    logic [POS_W-1:0]   bitpos;
    logic [63:0]        plane_acc_next;
    logic [7:0]         mask_acc_next;
    logic [3:0]         planes_eff;
    logic [PAL_CW-1:0]  limit_eff;

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && (32'(entry_index) < PAL_DEPTH))
        begin
            pal_mem[entry_index[PAL_AW-1:0]] <= {red[3:0], green[3:0], blue[3:0]};
        end
        if (cmd.step && !addr_end)
        begin
            rd_data_reg <= pal_mem[addr_reg[PAL_AW-1:0]];
            rd_idx_reg  <= addr_reg[PAL_AW-1:0];
        end
    end

    always_comb
    begin
        if (plane_count_reg == 4'd0)
        begin
            planes_eff = 4'd1;
        end
        else if (32'(plane_count_reg) > MAX_PLANES)
        begin
            planes_eff = 4'(MAX_PLANES);
        end
        else
        begin
            planes_eff = plane_count_reg;
        end
        if (32'(palette_size_reg) > PAL_DEPTH)
        begin
            limit_eff = PAL_CW'(PAL_DEPTH);
        end
        else
        begin
            limit_eff = PAL_CW'(palette_size_reg);
        end
    end

    assign addr_end = (addr_reg >= limit_reg);
    assign hit      = rd_vld_reg && (rd_data_reg == key_reg);
    assign bitpos   = POS_W'(GROUP_PIXELS - 1) - pos_reg;

    assign status.done     = transp_reg || hit || (!rd_vld_reg && addr_end);
    assign status.last     = (pos_reg == POS_W'(GROUP_PIXELS - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (transp_reg)
        begin
            idx_raw = masked_reg ? MASKED_INDEX : 8'd0;
        end
        else if (hit)
        begin
            idx_raw = 8'(rd_idx_reg);
        end
        else
        begin
            idx_raw = 8'd0;
        end
        if (!transp_reg && masked_reg && ({1'b0, idx_raw} >= (9'd1 << planes_reg)))
        begin
            idx = MASKED_INDEX;
        end
        else
        begin
            idx = idx_raw;
        end
        plane_acc_next = plane_acc_reg;
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            if ((4'(p) < planes_reg) && idx[p])
            begin
                plane_acc_next[8 * p + int'(bitpos)] = 1'b1;
            end
        end
        mask_acc_next = mask_acc_reg;
        if (masked_reg && (idx != MASKED_INDEX))
        begin
            mask_acc_next[bitpos] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg    <= {red[7:4], green[7:4], blue[7:4]};
            transp_reg <= transp_en_reg && (raster_index == transp_index_reg);
            masked_reg <= masked_mode_reg;
            planes_reg <= planes_eff;
            limit_reg  <= limit_eff;
        end
        if (cmd.emit)
        begin
            plane_out_reg   <= plane_acc_reg;
            mask_out_reg    <= masked_reg ? mask_acc_reg : 8'd0;
            missing_out_reg <= missing_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            pos_reg       <= '0;
            plane_acc_reg <= '0;
            mask_acc_reg  <= '0;
            missing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                addr_reg   <= '0;
                rd_vld_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                rd_vld_reg <= !addr_end;
                if (!addr_end)
                begin
                    addr_reg <= addr_reg + PAL_CW'(1);
                end
            end
            if (cmd.apply)
            begin
                plane_acc_reg <= plane_acc_next;
                mask_acc_reg  <= mask_acc_next;
                missing_reg   <= missing_reg | (!transp_reg && !hit);
                if (!status.last)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (cmd.emit)
            begin
                plane_acc_reg <= '0;
                mask_acc_reg  <= '0;
                missing_reg   <= 1'b0;
                pos_reg       <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = {mask_out_reg, plane_out_reg};
    assign out_missing = missing_out_reg;

endmodule

/* hdl/c2p_checker.sv */
module c2p_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [c2p_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic [0:0]                          m_axis_tuser
);
    import c2p_pkg::*;

    logic s_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed or dropped while stalled");

    // drop valid only after a transfer
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result withdrawn without transfer");

    // a pixel transfer starts a palette search
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && (s_axis_tuser[0] == CMD_PIXEL) |=> !s_axis_tready)
        else $error("input taken during palette search");

    // a palette load leaves the input ready
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && (s_axis_tuser[0] == CMD_LOAD) |=> s_axis_tready)
        else $error("palette load stalled the input");

    // a fresh result never appears in the cycle after an input transfer
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !$rose(m_axis_tvalid))
        else $error("unexpected result timing");

endmodule

bind palette_chunky_to_planar c2p_checker u_c2p_checker (.*);
